FILE: sv/ptwa_pkg.sv
package ptwa_pkg;

  // Default sizes
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int PATH_BYTES_DEF    = 20;

  // Path field: 20 bytes split over low, mid and high words
  localparam int PATH_MAX_BYTES = 20;
  localparam int PATH_MAX_W     = PATH_MAX_BYTES * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PORT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PATH_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PATH_MID  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PATH_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE          = 3'd4;

  localparam logic [31:0] MAX_AGE_RESET = 32'd60;

  // Request codes
  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_REMOVE = 3'd1;
  localparam logic [2:0] FN_LOOKUP = 3'd2;
  localparam logic [2:0] FN_TOUCH  = 3'd3;
  localparam logic [2:0] FN_TICK   = 3'd4;
  localparam logic [2:0] FN_PURGE  = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUP       = 3'd3;
  localparam logic [2:0] ST_PROTECTED = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] port;
    logic [63:0] path_low;
    logic [63:0] path_mid;
    logic [31:0] path_high;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  found_slot;
    logic [63:0] found_path_low;
    logic [63:0] found_path_mid;
    logic [31:0] found_path_high;
    logic [4:0]  entries_in_use;
    logic [3:0]  purged_count;
  } rsp_t;

  // Per-entry result of the shared compare unit
  typedef struct packed {
    logic port_eq;
    logic aged;
  } scan_res_t;

  // Keep bytes up to the first zero byte and below nbytes, clear the rest.
  // Byte 0 sits in bits 7:0.
  function automatic logic [PATH_MAX_W-1:0] norm_path(input logic [PATH_MAX_W-1:0] p,
                                                       input int nbytes);
    logic [PATH_MAX_W-1:0] o;
    logic                  ended;
    o     = '0;
    ended = 1'b0;
    for (int i = 0; i < PATH_MAX_BYTES; i++) begin
      if (i >= nbytes || p[i*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        o[i*8 +: 8] = p[i*8 +: 8];
      end
    end
    return o;
  endfunction

endpackage

FILE: sv/ptwa_mem.sv
module ptwa_mem #(
  parameter int DEPTH  = 16,
  parameter int SLOT_W = 4,
  parameter int PATH_W = 160
) (
  input  logic              clk,
  // scan read port, data registered
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [15:0]       rd_port,
  output logic [PATH_W-1:0] rd_path,
  output logic [31:0]       rd_stamp,
  // write port
  input  logic              we_entry,
  input  logic              we_stamp,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [15:0]       wr_port,
  input  logic [PATH_W-1:0] wr_path,
  input  logic [31:0]       wr_stamp
);

  logic [15:0]       port_mem  [DEPTH];
  logic [PATH_W-1:0] path_mem  [DEPTH];
  logic [31:0]       stamp_mem [DEPTH];

  // Key and path change only on insert; the stamp also on touch
  always_ff @(posedge clk) begin
    if (we_entry) begin
      port_mem[wr_addr] <= wr_port;
      path_mem[wr_addr] <= wr_path;
    end
    if (we_stamp) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    rd_port  <= port_mem[rd_addr];
    rd_path  <= path_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
  end

endmodule

FILE: sv/ptwa_cmp.sv
module ptwa_cmp (
  input  logic [15:0]         key_port,
  input  logic [15:0]         ent_port,
  input  logic [31:0]         time_now,
  input  logic [31:0]         ent_stamp,
  input  logic [31:0]         max_age,
  output ptwa_pkg::scan_res_t res
);

  logic [31:0] age;

  // Age wraps modulo 2^32
  assign age         = time_now - ent_stamp;
  assign res.port_eq = (key_port == ent_port);
  assign res.aged    = (age > max_age);

endmodule

FILE: sv/port_table_with_aging.sv
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_ready      ptwa_pkg::req_t req_data
// rsp       out        rsp_valid / rsp_ready      ptwa_pkg::rsp_t rsp_data
// cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// Insert, remove, lookup, touch and purge scan slots 1..TABLE_ENTRIES-1 one per
// cycle through the entry memory read port, then resolve in the final step.
// Tick and unknown codes skip the scan. One request is in work at a time.
// The last step waits while the response register still holds an untaken response.
// Reset is synchronous and at once empties all slots but slot 0 via per-slot valid bits.
module port_table_with_aging #(
  parameter int TABLE_ENTRIES = ptwa_pkg::TABLE_ENTRIES_DEF,
  parameter int PATH_BYTES    = ptwa_pkg::PATH_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  ptwa_pkg::req_t                  req_data,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output ptwa_pkg::rsp_t                  rsp_data,
  input  logic                            cfg_we,
  input  logic [ptwa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptwa_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int PATH_W = PATH_BYTES * 8;
  localparam int PMAX_W = ptwa_pkg::PATH_MAX_W;

  localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]               state;
  ptwa_pkg::req_t           cur;

  // configuration
  logic [15:0]              server_port;
  logic [63:0]              server_path_low;
  logic [63:0]              server_path_mid;
  logic [31:0]              server_path_high;
  logic [31:0]              max_age;

  // table state
  logic [TABLE_ENTRIES-1:0] vbits;
  logic [CNT_W-1:0]         count;
  logic [31:0]              time_now;

  // scan state
  logic [SLOT_W-1:0]        scan_addr;
  logic                     iss_done;
  logic                     rd_vld;
  logic [SLOT_W-1:0]        rd_idx;
  logic                     hit_found;
  logic [SLOT_W-1:0]        hit_idx;
  logic [PATH_W-1:0]        hit_path;
  logic                     free_found;
  logic [SLOT_W-1:0]        free_idx;
  logic [CNT_W-1:0]         purged;

  // memory read data
  logic [15:0]              rd_port;
  logic [PATH_W-1:0]        rd_path;
  logic [31:0]              rd_stamp;

  ptwa_pkg::scan_res_t      sres;
  logic                     ent_v;

  // final step
  logic                     fin_fire;
  logic                     srv_hit;
  logic                     any_hit;
  logic [SLOT_W-1:0]        hit_slot;
  logic [PMAX_W-1:0]        srv_path;
  logic [PMAX_W-1:0]        ins_path;
  logic [PMAX_W-1:0]        pout;
  logic [2:0]               st;
  logic [SLOT_W-1:0]        slot;
  logic                     ins_en;
  logic                     stamp_en;
  logic                     clr_en;
  logic                     tick;
  logic [SLOT_W-1:0]        wr_addr;
  logic [CNT_W-1:0]         cnt_fin;
  ptwa_pkg::rsp_t           res;

  assign req_ready = (state == S_IDLE);
  assign fin_fire  = (state == S_FIN) && (!rsp_valid || rsp_ready);

  // Entry memory
  ptwa_mem #(
    .DEPTH  (TABLE_ENTRIES),
    .SLOT_W (SLOT_W),
    .PATH_W (PATH_W)
  ) u_mem (
    .clk      (clk),
    .rd_addr  (scan_addr),
    .rd_port  (rd_port),
    .rd_path  (rd_path),
    .rd_stamp (rd_stamp),
    .we_entry (fin_fire && ins_en),
    .we_stamp (fin_fire && (ins_en || stamp_en)),
    .wr_addr  (wr_addr),
    .wr_port  (cur.port),
    .wr_path  (ins_path[PATH_W-1:0]),
    .wr_stamp (time_now)
  );

  // Shared compare unit, one slot per cycle
  ptwa_cmp u_cmp (
    .key_port  (cur.port),
    .ent_port  (rd_port),
    .time_now  (time_now),
    .ent_stamp (rd_stamp),
    .max_age   (max_age),
    .res       (sres)
  );

  assign ent_v = vbits[rd_idx];

  // Normalized paths
  assign srv_path = ptwa_pkg::norm_path({server_path_high, server_path_mid, server_path_low},
                                        PATH_BYTES);
  assign ins_path = ptwa_pkg::norm_path({cur.path_high, cur.path_mid, cur.path_low},
                                        PATH_BYTES);

  // Resolve the request once the scan is over; slot zero wins the search
  always_comb begin
    srv_hit  = (cur.port == server_port);
    any_hit  = srv_hit || hit_found;
    hit_slot = srv_hit ? '0 : hit_idx;
    st       = ptwa_pkg::ST_OK;
    slot     = '0;
    pout     = '0;
    ins_en   = 1'b0;
    stamp_en = 1'b0;
    clr_en   = 1'b0;
    tick     = 1'b0;
    wr_addr  = hit_idx;
    cnt_fin  = count;
    case (cur.func)
      ptwa_pkg::FN_INSERT: begin
        if (any_hit) begin
          st   = ptwa_pkg::ST_DUP;
          slot = hit_slot;
        end else if (free_found) begin
          ins_en  = 1'b1;
          wr_addr = free_idx;
          slot    = free_idx;
          cnt_fin = count + CNT_W'(1);
        end else begin
          st = ptwa_pkg::ST_FULL;
        end
      end
      ptwa_pkg::FN_REMOVE: begin
        if (!any_hit) begin
          st = ptwa_pkg::ST_NOT_FOUND;
        end else if (srv_hit) begin
          st = ptwa_pkg::ST_PROTECTED;
        end else begin
          clr_en  = 1'b1;
          slot    = hit_idx;
          cnt_fin = count - CNT_W'(1);
        end
      end
      ptwa_pkg::FN_LOOKUP: begin
        if (!any_hit) begin
          st = ptwa_pkg::ST_NOT_FOUND;
        end else begin
          slot = hit_slot;
          pout = srv_hit ? srv_path : PMAX_W'(hit_path);
        end
      end
      ptwa_pkg::FN_TOUCH: begin
        if (!any_hit) begin
          st = ptwa_pkg::ST_NOT_FOUND;
        end else begin
          slot     = hit_slot;
          stamp_en = !srv_hit;
        end
      end
      ptwa_pkg::FN_TICK: begin
        tick = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status          = st;
    res.found_slot      = 4'(slot);
    res.found_path_low  = pout[63:0];
    res.found_path_mid  = pout[127:64];
    res.found_path_high = pout[159:128];
    res.entries_in_use  = 5'(cnt_fin);
    res.purged_count    = 4'(purged);
  end

  // Sequencer, table state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      rsp_valid        <= 1'b0;
      vbits            <= TABLE_ENTRIES'(1);
      count            <= CNT_W'(1);
      time_now         <= '0;
      rd_vld           <= 1'b0;
      iss_done         <= 1'b0;
      server_port      <= '0;
      server_path_low  <= '0;
      server_path_mid  <= '0;
      server_path_high <= '0;
      max_age          <= ptwa_pkg::MAX_AGE_RESET;
    end else begin
      // config writes
      if (cfg_we) begin
        case (cfg_index)
          ptwa_pkg::CFG_SERVER_PORT:      server_port      <= cfg_data[15:0];
          ptwa_pkg::CFG_SERVER_PATH_LOW:  server_path_low  <= cfg_data;
          ptwa_pkg::CFG_SERVER_PATH_MID:  server_path_mid  <= cfg_data;
          ptwa_pkg::CFG_SERVER_PATH_HIGH: server_path_high <= cfg_data[31:0];
          ptwa_pkg::CFG_MAX_AGE:          max_age          <= cfg_data[31:0];
          default: begin
          end
        endcase
      end

      if (rsp_valid && rsp_ready && !fin_fire) begin
        rsp_valid <= 1'b0;
      end

      rd_vld <= (state == S_SCAN) && !iss_done;
      rd_idx <= scan_addr;

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur        <= req_data;
            scan_addr  <= FIRST_SLOT;
            iss_done   <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            purged     <= '0;
            if (req_data.func inside {ptwa_pkg::FN_INSERT, ptwa_pkg::FN_REMOVE,
                                      ptwa_pkg::FN_LOOKUP, ptwa_pkg::FN_TOUCH,
                                      ptwa_pkg::FN_PURGE}) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          // issue reads
          if (!iss_done) begin
            scan_addr <= scan_addr + SLOT_W'(1);
            if (scan_addr == LAST_SLOT) begin
              iss_done <= 1'b1;
            end
          end
          // evaluate the slot read last cycle
          if (rd_vld) begin
            if (ent_v && sres.port_eq && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
              hit_path  <= rd_path;
            end
            if (!ent_v && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (cur.func == ptwa_pkg::FN_PURGE && ent_v && sres.aged) begin
              vbits[rd_idx] <= 1'b0;
              count         <= count - CNT_W'(1);
              purged        <= purged + CNT_W'(1);
            end
            if (rd_idx == LAST_SLOT) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            if (ins_en) begin
              vbits[free_idx] <= 1'b1;
            end
            if (clr_en) begin
              vbits[hit_idx] <= 1'b0;
            end
            if (tick) begin
              time_now <= time_now + 32'd1;
            end
            count     <= cnt_fin;
            rsp_data  <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/ptwa_check.sv
module ptwa_check (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input ptwa_pkg::rsp_t rsp_data
);

  // After reset no response is pending and the block waits for a request
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("not idle after reset");

  // One request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed under stall");

  // A miss reports no slot and no path
  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ptwa_pkg::ST_NOT_FOUND |->
      rsp_data.found_slot == 4'd0 && rsp_data.found_path_low == 64'd0 &&
      rsp_data.found_path_mid == 64'd0 && rsp_data.found_path_high == 32'd0)
    else $error("miss with slot or path");

  // Full table and protected entry both point at slot zero, and nothing is purged
  a_reject_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == ptwa_pkg::ST_FULL ||
                  rsp_data.status == ptwa_pkg::ST_PROTECTED) |->
      rsp_data.found_slot == 4'd0 && rsp_data.purged_count == 4'd0)
    else $error("rejected request with slot or purge count");

endmodule

bind port_table_with_aging ptwa_check u_ptwa_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);
